// ===== rtl/stereo_through_zero_flanger_macros.svh =====
// Assertion shorthands shared by the flanger RTL.
`ifndef STEREO_THROUGH_ZERO_FLANGER_MACROS_SVH
`define STEREO_THROUGH_ZERO_FLANGER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define STZFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define STZFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stzfl_pkg.sv =====
`timescale 1ns / 1ps
package stzfl_pkg;

  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned LINE_DEPTH_DEF  = 1024;
  localparam int unsigned SINE_TABLE_SIZE = 256;
  localparam int unsigned SINE_BITS       = $clog2(SINE_TABLE_SIZE);
  localparam int unsigned FB_MAX          = 31130;
  localparam int unsigned MIX_MAX         = 32768;
  // integer part of the largest delay, rounded up
  localparam int unsigned DELAY_INT_W     = 13;

  typedef enum logic [2:0] {
    REG_LINE_LENGTH   = 3'd0,
    REG_BASE_DELAY    = 3'd1,
    REG_DEPTH         = 3'd2,
    REG_LFO_INCREMENT = 3'd3,
    REG_FEEDBACK_GAIN = 3'd4,
    REG_WET_MIX       = 3'd5,
    REG_LFO_SHAPE     = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_TRIANGLE = 2'd1,
    SHAPE_SAW      = 2'd2,
    SHAPE_SQUARE   = 2'd3
  } lfo_shape_e;

  typedef enum logic [2:0] {
    MUL_DEPTH = 3'd0,
    MUL_IL    = 3'd1,
    MUL_IR    = 3'd2,
    MUL_FBL   = 3'd3,
    MUL_FBR   = 3'd4,
    MUL_MXL   = 3'd5,
    MUL_MXR   = 3'd6
  } mul_sel_e;

  typedef struct packed {
    logic     clear_wr;
    logic     load;
    logic     mod_load;
    logic     mod_src_d;
    logic     mod_step;
    logic     w_take;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     delay_en;
    logic     pos_en;
    logic     rd_en;
    logic     rd_i1;
    logic     x0_en;
    logic     dl_en;
    logic     dr_en;
    logic     fbl_en;
    logic     fbr_en;
    logic     ol_en;
    logic     commit;
  } stzfl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic w_ge_len;
    logic d_ge_len;
    logic mod_last;
  } stzfl_status_t;

  typedef logic [15:0] sine_tab_t [SINE_TABLE_SIZE+1];

  // Quarter-wave sine in Q15 from a Q30 odd polynomial.
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint c [6];
    longint t, t2, r, s;
    c[0] = 64'sd1686629713;
    c[1] = -64'sd693598664;
    c[2] = 64'sd85569328;
    c[3] = -64'sd5026995;
    c[4] = 64'sd172270;
    c[5] = -64'sd3864;
    for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
      t  = longint'(k) <<< (30 - SINE_BITS);
      t2 = (t * t) >>> 30;
      r  = c[5];
      for (int j = 4; j >= 0; j--) begin
        r = c[j] + ((r * t2) >>> 30);
      end
      s = (((r * t) >>> 30) + 64'sd16384) >>> 15;
      if (s < 0) s = 0;
      if (s > 32768) s = 32768;
      tab[k] = 16'(s);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Clip a widened sum to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAMPLE_BITS+1:0] v
  );
    logic signed [SAMPLE_BITS+1:0] hi, lo;
    hi = (SAMPLE_BITS+2)'((1 << (SAMPLE_BITS - 1)) - 1);
    lo = -(SAMPLE_BITS+2)'(1 << (SAMPLE_BITS - 1));
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== rtl/stzfl_datapath.sv =====
`timescale 1ns / 1ps
`include "stereo_through_zero_flanger_macros.svh"
module stzfl_datapath import stzfl_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [23:0]                 cfg_data_i,
  input  logic [2*SAMPLE_BITS-1:0]    in_data_i,
  input  stzfl_cmd_t                  cmd_i,
  output stzfl_status_t               status_o,
  output logic [2*SAMPLE_BITS-1:0]    out_data_o
);

  localparam int unsigned IW  = $clog2(LINE_DEPTH);
  localparam int unsigned LW  = $clog2(LINE_DEPTH + 1);
  localparam int unsigned RMW = (IW > DELAY_INT_W) ? IW : DELAY_INT_W;
  localparam int unsigned KW  = $clog2(RMW);
  localparam int unsigned CW  = RMW + LW;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // configuration registers
  logic [10:0] len_cfg_q;
  logic [17:0] base_q, depth_q;
  logic [23:0] inc_q;
  logic [14:0] gain_q;
  logic [15:0] mix_q;
  lfo_shape_e  shape_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= 11'd256;
      base_q    <= 18'd32768;
      depth_q   <= 18'd16384;
      inc_q     <= 24'd44739;
      gain_q    <= 15'd16384;
      mix_q     <= 16'd16384;
      shape_q   <= SHAPE_SINE;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_LINE_LENGTH:   len_cfg_q <= cfg_data_i[10:0];
        REG_BASE_DELAY:    base_q    <= cfg_data_i[17:0];
        REG_DEPTH:         depth_q   <= cfg_data_i[17:0];
        REG_LFO_INCREMENT: inc_q     <= cfg_data_i;
        REG_FEEDBACK_GAIN: gain_q    <= cfg_data_i[14:0];
        REG_WET_MIX:       mix_q     <= cfg_data_i[15:0];
        REG_LFO_SHAPE:     shape_q   <= lfo_shape_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // clamp length, gain and mix
  logic [LW-1:0] len;
  logic [14:0]   gain_eff;
  logic [15:0]   mix_eff;

  always_comb begin
    if (len_cfg_q < 11'd4) begin
      len = LW'(4);
    end else if (32'(len_cfg_q) > 32'(LINE_DEPTH)) begin
      len = LW'(LINE_DEPTH);
    end else begin
      len = LW'(len_cfg_q);
    end
    gain_eff = (32'(gain_q) > FB_MAX) ? 15'(FB_MAX) : gain_q;
    mix_eff  = (32'(mix_q) > MIX_MAX) ? 16'(MIX_MAX) : mix_q;
  end

  // LFO value at the current phase
  logic [31:0]            phase_q;
  logic signed [16:0]     lfo_q, lfo_d;
  logic [SINE_BITS-1:0]   sin_i;
  logic [SINE_BITS:0]     sin_idx;
  logic [16:0]            sin_m;
  logic [14:0]            p15;
  int                     wave;

  always_comb begin
    sin_i   = phase_q[29 -: SINE_BITS];
    sin_idx = phase_q[30] ? ((SINE_BITS+1)'(SINE_TABLE_SIZE) - {1'b0, sin_i})
                          : {1'b0, sin_i};
    sin_m   = {1'b0, SINE_TAB[sin_idx]};
    p15     = phase_q[31:17];
    case (shape_q)
      SHAPE_SINE:     wave = phase_q[31] ? -int'(sin_m) : int'(sin_m);
      SHAPE_TRIANGLE: wave = phase_q[31] ? 98304 - 4 * int'(p15) : 4 * int'(p15) - 32768;
      SHAPE_SAW:      wave = 2 * int'(p15) - 32768;
      default:        wave = phase_q[31] ? -32768 : 32768;
    endcase
    lfo_d = 17'(wave);
  end

  // input capture, phase and write index
  smp_t          xl_q, xr_q;
  logic [IW-1:0] index_q;
  logic [LW-1:0] idx_nxt;
  logic [RMW-1:0] rem_q;

  assign idx_nxt = LW'(index_q) + LW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      index_q <= '0;
    end else begin
      if (cmd_i.load) phase_q <= phase_q + 32'(inc_q);
      if (cmd_i.w_take) begin
        index_q <= IW'(rem_q);
      end else if (cmd_i.commit) begin
        index_q <= (idx_nxt == len) ? '0 : IW'(idx_nxt);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xl_q  <= in_data_i[SAMPLE_BITS-1:0];
      xr_q  <= in_data_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
      lfo_q <= lfo_d;
    end
  end

  // shared multiplier
  logic signed [18:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [36:0] prod_q;
  logic [7:0]         frac_q;
  smp_t               x0l_q, x0r_q, rdl_q, rdr_q;
  smp_t               dl_q, dr_q, fbl_q, fbr_q, ol_q;
  logic               neg_q;

  always_comb begin
    mul_a = $signed({1'b0, depth_q});
    mul_b = 18'(lfo_q);
    case (cmd_i.mul_sel)
      MUL_DEPTH: begin
        mul_a = $signed({1'b0, depth_q});
        mul_b = 18'(lfo_q);
      end
      MUL_IL: begin
        mul_a = $signed({11'b0, frac_q});
        mul_b = 18'(17'(rdl_q) - 17'(x0l_q));
      end
      MUL_IR: begin
        mul_a = $signed({11'b0, frac_q});
        mul_b = 18'(17'(rdr_q) - 17'(x0r_q));
      end
      MUL_FBL: begin
        mul_a = $signed({4'b0, gain_eff});
        mul_b = 18'(neg_q ? dr_q : dl_q);
      end
      MUL_FBR: begin
        mul_a = $signed({4'b0, gain_eff});
        mul_b = 18'(neg_q ? dl_q : dr_q);
      end
      MUL_MXL: begin
        mul_a = $signed({3'b0, mix_eff});
        mul_b = 18'(17'(dl_q) - 17'(xl_q));
      end
      MUL_MXR: begin
        mul_a = $signed({3'b0, mix_eff});
        mul_b = 18'(17'(dr_q) - 17'(xr_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
  end

  // rounded views of the product
  logic signed [36:0] rnd8, rnd15;
  assign rnd8  = (prod_q + 37'sd128) >>> 8;
  assign rnd15 = (prod_q + 37'sd16384) >>> 15;

  // delay: magnitude, sign, integer part rounded up and read fraction
  logic signed [20:0]       delay_s;
  logic [19:0]              mag;
  logic [DELAY_INT_W-1:0]   di_q;

  assign delay_s = $signed({3'b0, base_q}) + 21'(rnd15);
  assign mag     = delay_s[20] ? 20'(-delay_s) : 20'(delay_s);

  always_ff @(posedge clk_i) begin
    if (cmd_i.delay_en) begin
      neg_q  <= delay_s[20];
      di_q   <= DELAY_INT_W'(mag[19:8]) + DELAY_INT_W'(mag[7:0] != 8'd0);
      frac_q <= 8'd0 - mag[7:0];
    end
  end

  // remainder unit: subtract shifted length, one bit a cycle
  logic [KW-1:0] k_q;
  logic [CW-1:0] shifted, rem_ext;

  assign shifted = CW'(len) << k_q;
  assign rem_ext = CW'(rem_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_load) begin
      rem_q <= cmd_i.mod_src_d ? RMW'(di_q) : RMW'(index_q);
      k_q   <= KW'(RMW - 1);
    end else if (cmd_i.mod_step) begin
      if (rem_ext >= shifted) rem_q <= RMW'(rem_ext - shifted);
      k_q <= k_q - KW'(1);
    end
  end

  // read positions
  logic [IW-1:0] i0_q, i1_q;
  logic [LW-1:0] r_len, pos_int, pos_inc;
  logic [LW:0]   pos_wrap;

  always_comb begin
    r_len    = LW'(rem_q);
    pos_wrap = (LW+1)'(index_q) + (LW+1)'(len) - (LW+1)'(r_len);
    pos_int  = (LW'(index_q) >= r_len) ? LW'(index_q) - r_len : LW'(pos_wrap);
    pos_inc  = pos_int + LW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_en) begin
      i0_q <= IW'(pos_int);
      i1_q <= (pos_inc == len) ? '0 : IW'(pos_inc);
    end
  end

  // delay line memories
  smp_t          mem_l [LINE_DEPTH];
  smp_t          mem_r [LINE_DEPTH];
  logic [IW-1:0] clr_q;
  logic [IW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  smp_t          wr_l, wr_r;

  assign rd_addr = cmd_i.rd_i1 ? i1_q : i0_q;
  assign wr_en   = cmd_i.clear_wr | cmd_i.commit;
  assign wr_addr = cmd_i.clear_wr ? clr_q : index_q;
  assign wr_l    = cmd_i.clear_wr ? '0 : sat_sample(18'(xl_q) + 18'(fbr_q));
  assign wr_r    = cmd_i.clear_wr ? '0 : sat_sample(18'(xr_q) + 18'(fbl_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_q <= clr_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_l[wr_addr] <= wr_l;
      mem_r[wr_addr] <= wr_r;
    end
    if (cmd_i.rd_en) begin
      rdl_q <= mem_l[rd_addr];
      rdr_q <= mem_r[rd_addr];
    end
  end

  // interpolation, feedback and mix results
  smp_t or_d;
  assign or_d = sat_sample(18'(xr_q) + 18'(rnd15));

  always_ff @(posedge clk_i) begin
    if (cmd_i.x0_en) begin
      x0l_q <= rdl_q;
      x0r_q <= rdr_q;
    end
    if (cmd_i.dl_en)  dl_q  <= x0l_q + SAMPLE_BITS'(rnd8);
    if (cmd_i.dr_en)  dr_q  <= x0r_q + SAMPLE_BITS'(rnd8);
    if (cmd_i.fbl_en) fbl_q <= SAMPLE_BITS'(rnd15);
    if (cmd_i.fbr_en) fbr_q <= SAMPLE_BITS'(rnd15);
    if (cmd_i.ol_en)  ol_q  <= sat_sample(18'(xl_q) + 18'(rnd15));
    if (cmd_i.commit) out_data_o <= {or_d, ol_q};
  end

  assign status_o.clear_last = (clr_q == IW'(LINE_DEPTH - 1));
  assign status_o.w_ge_len   = (LW'(index_q) >= len);
  assign status_o.d_ge_len   = (CW'(di_q) >= CW'(len));
  assign status_o.mod_last   = (k_q == '0);

  `STZFL_ASSERT_IMP(a_pos_rem_in_range, clk_i, rst_ni, cmd_i.pos_en, CW'(rem_q) < CW'(len), "remainder not below line length")
  `STZFL_ASSERT_IMP(a_read_in_line, clk_i, rst_ni, cmd_i.rd_en, LW'(rd_addr) < len, "read address beyond line length")
  `STZFL_ASSERT_IMP(a_write_in_line, clk_i, rst_ni, cmd_i.commit, LW'(index_q) < len, "write index beyond line length")

endmodule

// ===== rtl/stzfl_ctrl.sv =====
`timescale 1ns / 1ps
`include "stereo_through_zero_flanger_macros.svh"
module stzfl_ctrl import stzfl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  stzfl_status_t status_i,
  output stzfl_cmd_t    cmd_o
);

  typedef enum logic [19:0] {
    S_CLEAR = 20'h00001,
    S_IDLE  = 20'h00002,
    S_WCHK  = 20'h00004,
    S_WMOD  = 20'h00008,
    S_WSET  = 20'h00010,
    S_MDEL  = 20'h00020,
    S_DELAY = 20'h00040,
    S_PCHK  = 20'h00080,
    S_PMOD  = 20'h00100,
    S_POS   = 20'h00200,
    S_RD0   = 20'h00400,
    S_RD1   = 20'h00800,
    S_IL    = 20'h01000,
    S_IR    = 20'h02000,
    S_IRD   = 20'h04000,
    S_FBL   = 20'h08000,
    S_FBR   = 20'h10000,
    S_MXL   = 20'h20000,
    S_MXR   = 20'h40000,
    S_DONE  = 20'h80000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // sequence one word through the datapath
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WCHK;
        end
      end
      S_WCHK: begin
        cmd_o.mod_load = 1'b1;
        state_d        = status_i.w_ge_len ? S_WMOD : S_MDEL;
      end
      S_WMOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) state_d = S_WSET;
      end
      S_WSET: begin
        cmd_o.w_take = 1'b1;
        state_d      = S_MDEL;
      end
      S_MDEL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DEPTH;
        state_d       = S_DELAY;
      end
      S_DELAY: begin
        cmd_o.delay_en = 1'b1;
        state_d        = S_PCHK;
      end
      S_PCHK: begin
        cmd_o.mod_load  = 1'b1;
        cmd_o.mod_src_d = 1'b1;
        state_d         = status_i.d_ge_len ? S_PMOD : S_POS;
      end
      S_PMOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) state_d = S_POS;
      end
      S_POS: begin
        cmd_o.pos_en = 1'b1;
        state_d      = S_RD0;
      end
      S_RD0: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_i1 = 1'b1;
        cmd_o.x0_en = 1'b1;
        state_d     = S_IL;
      end
      S_IL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_IL;
        state_d       = S_IR;
      end
      S_IR: begin
        cmd_o.dl_en   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_IR;
        state_d       = S_IRD;
      end
      S_IRD: begin
        cmd_o.dr_en = 1'b1;
        state_d     = S_FBL;
      end
      S_FBL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_FBL;
        state_d       = S_FBR;
      end
      S_FBR: begin
        cmd_o.fbl_en  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_FBR;
        state_d       = S_MXL;
      end
      S_MXL: begin
        cmd_o.fbr_en  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_MXL;
        state_d       = S_MXR;
      end
      S_MXR: begin
        cmd_o.ol_en   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_MXR;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold the result word until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `STZFL_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, out_valid_q && !out_ready_i, !cmd_o.commit, "result overwritten before taken")
  `STZFL_ASSERT_NXT(a_commit_valid, clk_i, rst_ni, cmd_o.commit, out_valid_q, "commit did not raise valid")
  `STZFL_ASSERT_IMP(a_clear_blocks_input, clk_i, rst_ni, state_q == S_CLEAR, !in_ready_o && !cmd_o.commit, "word taken during line clear")

endmodule

// ===== rtl/stereo_through_zero_flanger.sv =====
`timescale 1ns / 1ps
// Stereo through-zero flanger with crossed feedback. One stereo sample pair
// goes in per input word and one mixed pair comes out per output word. After
// reset both delay lines (LINE_DEPTH entries, 1024 by default) are cleared,
// one entry per cycle, during which no input word is taken; the config
// port works during that time and must only be written while the block is
// idle. Each word is sequenced through the single shared multiplier doing
// seven products in turn plus two reads per delay-line memory port, and no
// new word is taken until the last one has been committed. If the delay
// reaches or exceeds the line length the remainder unit runs its subtract
// steps, and after line_length shrinks to or below the stored write position
// it runs them once more, plus one step to take the result. A pending result
// does not block the next word from entering.
module stereo_through_zero_flanger import stzfl_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // in_left [15:0], in_right [31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // out_left [15:0], out_right [31:16]
);

  stzfl_cmd_t    cmd;
  stzfl_status_t status;

  stzfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stzfl_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata)
  );

endmodule
